@@ src/cfla_pkg.sv @@
// Shared types and constants for the cell free-list allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cfla_pkg;

   localparam int CELL_W          = 10;
   localparam int LINK_DEPTH      = 1 << CELL_W;
   localparam int COUNT_W         = 11;
   localparam int BLOCKS_OUT_W    = 5;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 11;
   localparam int CELLS_PER_BLOCK = 64;
   localparam int MAX_BLOCKS      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIFO_ORDER = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FREE   = 1'd1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CELL_W-1:0] cell_req;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [CELL_W-1:0]       granted;
      logic [COUNT_W-1:0]      free_total;
      logic [BLOCKS_OUT_W-1:0] blocks_used;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } link_wr_type;

endpackage

@@ src/cfla_link_ram.sv @@
// Link memory: next-cell pointer of every cell on the free list.
// One write port, one registered read port. Depends on cfla_pkg.
`timescale 1ns / 1ps
module cfla_link_ram (
   input  logic                       clock,
   input  cfla_pkg::link_wr_type      wr,
   input  logic [cfla_pkg::CELL_W-1:0] rd_addr,
   output logic [cfla_pkg::CELL_W-1:0] rd_data
);
   import cfla_pkg::*;

   logic [CELL_W-1:0] mem [LINK_DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cell_free_list_allocator.sv @@
// Top level of the cell free-list allocator: sequencer, list pointers and counters.
// Depends on cfla_pkg and cfla_link_ram.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. req_data.mode
//   selects allocate or free; req_data.cell_req names the cell being freed.
//   Exactly one result follows per request: rsp_valid is high for one cycle with
//   rsp_data, and must be taken in that cycle (the receiver cannot stall).
// Operation:
//   Free: one link-memory write at the accept edge; result on the next cycle,
//   busy never rises, so a request may follow every cycle.
//   Allocate: check, then pop through the registered link-memory read
//   when no growth is needed; the next request is taken at the end of the result cycle.
//   Growth adds a block one cell at a time, with one link write per cell linked
//   behind the tail through the single write port, then returns to the check
//   state. A failed allocation at the block limit answers from the check state.
// Configuration:
//   csr_we/csr_index/csr_wdata write lifo_order (index 0) or min_free (index 1)
//   at any edge; write only while the block is idle.
// Reset:
//   Synchronous, active high. Empties the list and clears both counters and both
//   registers. The link memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module cell_free_list_allocator #(
   parameter int CELLS_PER_BLOCK = cfla_pkg::CELLS_PER_BLOCK,
   parameter int MAX_BLOCKS      = cfla_pkg::MAX_BLOCKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  cfla_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output cfla_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [cfla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfla_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cfla_pkg::*;

   localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (CELLS_PER_BLOCK > 1) ? $clog2(CELLS_PER_BLOCK) : 1;
   localparam logic [BLK_W-1:0]   BLK_LIMIT = BLK_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(CELLS_PER_BLOCK - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GROW,
      ST_POP
   } state_type;

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  head_ff, head_in;
   logic [CELL_W-1:0]  tail_ff, tail_in;
   logic               nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [BLK_W-1:0]   blocks_ff, blocks_in;
   logic [CELL_W-1:0]  grow_cell_ff, grow_cell_in;
   logic [IDX_W-1:0]   grow_idx_ff, grow_idx_in;
   logic               lifo_ff, lifo_in;
   logic [COUNT_W-1:0] min_free_ff, min_free_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   link_wr_type        link_wr;
   logic [CELL_W-1:0]  link_rd;
   logic [COUNT_W-1:0] free_up, free_down;

   cfla_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (head_ff),
      .rd_data (link_rd)
   );

   assign free_up   = (free_ff != COUNT_MAX) ? free_ff + 1'b1 : free_ff;
   assign free_down = (free_ff != '0) ? free_ff - 1'b1 : free_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      free_in      = free_ff;
      blocks_in    = blocks_ff;
      grow_cell_in = grow_cell_ff;
      grow_idx_in  = grow_idx_ff;
      lifo_in      = lifo_ff;
      min_free_in  = min_free_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      link_wr      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_LIFO_ORDER: lifo_in     = csr_wdata[0];
            CSR_MIN_FREE:   min_free_in = csr_wdata[COUNT_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.mode == MODE_FREE) begin
                  if (lifo_ff) begin
                     link_wr.en   = nonempty_ff;
                     link_wr.addr = req_data.cell_req;
                     link_wr.data = head_ff;
                     head_in      = req_data.cell_req;
                     if (!nonempty_ff) begin
                        tail_in = req_data.cell_req;
                     end
                  end else begin
                     link_wr.en   = nonempty_ff;
                     link_wr.addr = tail_ff;
                     link_wr.data = req_data.cell_req;
                     tail_in      = req_data.cell_req;
                     if (!nonempty_ff) begin
                        head_in = req_data.cell_req;
                     end
                  end
                  nonempty_in         = 1'b1;
                  free_in             = free_up;
                  rsp_valid_in        = 1'b1;
                  rsp_in.ok           = 1'b1;
                  rsp_in.granted      = '0;
                  rsp_in.free_total   = free_up;
                  rsp_in.blocks_used  = BLOCKS_OUT_W'(blocks_ff);
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!nonempty_ff || (free_ff < min_free_ff)) begin
               if (blocks_ff >= BLK_LIMIT) begin
                  state_in           = ST_IDLE;
                  rsp_valid_in       = 1'b1;
                  rsp_in.ok          = 1'b0;
                  rsp_in.granted     = '0;
                  rsp_in.free_total  = free_ff;
                  rsp_in.blocks_used = BLOCKS_OUT_W'(blocks_ff);
               end else begin
                  state_in    = ST_GROW;
                  grow_idx_in = '0;
               end
            end else begin
               state_in = ST_POP;
            end
         end
         ST_GROW: begin
            link_wr.en   = nonempty_ff;
            link_wr.addr = tail_ff;
            link_wr.data = grow_cell_ff;
            tail_in      = grow_cell_ff;
            if (!nonempty_ff) begin
               head_in = grow_cell_ff;
            end
            nonempty_in  = 1'b1;
            free_in      = free_up;
            grow_cell_in = grow_cell_ff + 1'b1;
            grow_idx_in  = grow_idx_ff + 1'b1;
            if (grow_idx_ff == IDX_LAST) begin
               blocks_in = blocks_ff + 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               nonempty_in = 1'b0;
            end else begin
               head_in = link_rd;
            end
            free_in            = free_down;
            state_in           = ST_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_in.ok          = 1'b1;
            rsp_in.granted     = head_ff;
            rsp_in.free_total  = free_down;
            rsp_in.blocks_used = BLOCKS_OUT_W'(blocks_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         nonempty_ff  <= 1'b0;
         free_ff      <= '0;
         blocks_ff    <= '0;
         grow_cell_ff <= '0;
         lifo_ff      <= 1'b0;
         min_free_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nonempty_ff  <= nonempty_in;
         free_ff      <= free_in;
         blocks_ff    <= blocks_in;
         grow_cell_ff <= grow_cell_in;
         lifo_ff      <= lifo_in;
         min_free_ff  <= min_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grow_idx_ff <= grow_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/cfla_checker.sv @@
// Port-level checks for cell_free_list_allocator, attached by bind.
// Depends on cfla_pkg.
`timescale 1ns / 1ps
module cfla_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input cfla_pkg::req_type req_data,
   input logic              rsp_valid,
   input cfla_pkg::rsp_type rsp_data
);
   import cfla_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_free_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_FREE) |=> rsp_valid && rsp_data.ok)
      else $error("free transfer without result on next cycle");

   a_alloc_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_ALLOC) |=> busy && !rsp_valid)
      else $error("allocate transfer did not start sequencer");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   a_fail_no_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.granted == '0))
      else $error("failed allocation reports a cell");

endmodule

bind cell_free_list_allocator cfla_checker u_cfla_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ verif/cell_free_list_allocator_checker.sv @@
// Checker for the cell free-list allocator: mirrors the linked free list and
// compares every result transfer with the predicted one. Depends on cfla_pkg.
`timescale 1ns / 1ps
module cell_free_list_allocator_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  cfla_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  cfla_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [cfla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfla_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               error_count,
   output int                               pending_count,
   output int                               checked_count
);
   import cfla_pkg::*;

   localparam int FREE_SAT = (1 << COUNT_W) - 1;

   logic [CELL_W-1:0] succ_cell [LINK_DEPTH];
   logic [CELL_W-1:0] head_ptr;
   logic [CELL_W-1:0] tail_ptr;
   logic              have_cells;
   int unsigned       free_cells;
   int unsigned       block_total;
   logic              push_front;
   int unsigned       grow_threshold;

   rsp_type list_op_results_due [$];
   int      mismatches = 0;
   int      checked = 0;

   function automatic void count_freed();
      if (free_cells < FREE_SAT) free_cells++;
   endfunction

   function automatic void link_at_tail(logic [CELL_W-1:0] c);
      if (have_cells) succ_cell[tail_ptr] = c;
      else head_ptr = c;
      tail_ptr   = c;
      have_cells = 1'b1;
      count_freed();
   endfunction

   function automatic logic grow_list();
      if (block_total >= MAX_BLOCKS) return 1'b0;
      for (int i = 0; i < CELLS_PER_BLOCK; i++) begin
         link_at_tail(CELL_W'((block_total * CELLS_PER_BLOCK + i) % LINK_DEPTH));
      end
      block_total++;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_list_op(req_type r);
      rsp_type           result;
      logic              grant_ok;
      logic [CELL_W-1:0] grant_cell;
      grant_ok   = 1'b1;
      grant_cell = '0;
      if (r.mode == MODE_ALLOC) begin
         while (!have_cells || free_cells < grow_threshold) begin
            if (!grow_list()) begin
               grant_ok = 1'b0;
               break;
            end
         end
         if (grant_ok) begin
            grant_cell = head_ptr;
            if (grant_cell == tail_ptr) have_cells = 1'b0;
            else head_ptr = succ_cell[grant_cell];
            if (free_cells > 0) free_cells--;
         end
      end else if (push_front) begin
         if (have_cells) succ_cell[r.cell_req] = head_ptr;
         else tail_ptr = r.cell_req;
         head_ptr   = r.cell_req;
         have_cells = 1'b1;
         count_freed();
      end else begin
         link_at_tail(r.cell_req);
      end
      result.ok          = grant_ok;
      result.granted     = grant_cell;
      result.free_total  = COUNT_W'(free_cells);
      result.blocks_used = BLOCKS_OUT_W'(block_total);
      return result;
   endfunction

   function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_ptr       = '0;
         tail_ptr       = '0;
         have_cells     = 1'b0;
         free_cells     = 0;
         block_total    = 0;
         push_front     = 1'b0;
         grow_threshold = 0;
         list_op_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LIFO_ORDER: push_front = csr_wdata[0];
               CSR_MIN_FREE:   grow_threshold = csr_wdata;
               default:        ;
            endcase
         end
         if (rsp_valid) begin
            if (list_op_results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing outstanding, actual %p", $time, rsp_data);
            end else begin
               want = list_op_results_due.pop_front();
               checked++;
               compare_field("ok", 16'(want.ok), 16'(rsp_data.ok));
               compare_field("granted", 16'(want.granted), 16'(rsp_data.granted));
               compare_field("free_total", 16'(want.free_total), 16'(rsp_data.free_total));
               compare_field("blocks_used", 16'(want.blocks_used),
                             16'(rsp_data.blocks_used));
            end
         end
         if (start && !busy) list_op_results_due.push_back(predict_list_op(req_data));
      end
      pending_count <= list_op_results_due.size();
      error_count   <= mismatches;
      checked_count <= checked;
   end

endmodule

@@ verif/cell_free_list_allocator_tb.sv @@
// Top of the cell free-list allocator testbench: clock, reset, request and
// register stimulus, verdict. Depends on cfla_pkg, the block and its checker.
`timescale 1ns / 1ps
module cell_free_list_allocator_tb;
   import cfla_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int error_count;
   int pending_count;
   int checked_count;

   logic              mode_log [$];
   logic [CELL_W-1:0] held_cells [$];
   int                alloc_sent = 0;
   int                free_sent = 0;
   int                csr_writes = 0;
   int                calm_left = 0;

   cell_free_list_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cell_free_list_allocator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && mode_log.size() > 0) begin
            if (mode_log.pop_front() == MODE_ALLOC && rsp_data.ok) begin
               held_cells.push_back(rsp_data.granted);
            end
         end
         if (start && !busy) mode_log.push_back(req_data.mode);
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic mode, input logic [CELL_W-1:0] cell_idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{mode: mode, cell_req: cell_idx};
      // hold until the transfer
      while (busy) @(negedge clock);
      @(posedge clock);
      if (mode == MODE_ALLOC) alloc_sent++;
      else free_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   task automatic random_phase(input int count, input int alloc_pct, input int noise_pct);
      int                idx;
      logic [CELL_W-1:0] c;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 59) == 0) drain();
         if ($urandom_range(0, 99) < alloc_pct) begin
            send_item(MODE_ALLOC, CELL_W'($urandom));
         end else if (held_cells.size() > 0 && $urandom_range(0, 99) >= noise_pct) begin
            idx = $urandom_range(0, held_cells.size() - 1);
            c   = held_cells[idx];
            held_cells.delete(idx);
            send_item(MODE_FREE, c);
         end else begin
            send_item(MODE_FREE, CELL_W'($urandom));
         end
      end
   endtask

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [CELL_W-1:0] c;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short FIFO list, then a LIFO re-free of a middle cell loops the list
      send_item(MODE_FREE, CELL_W'(1));
      send_item(MODE_FREE, CELL_W'(2));
      send_item(MODE_FREE, CELL_W'(3));
      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(1));
      send_item(MODE_FREE, CELL_W'(2));
      repeat (5) send_item(MODE_ALLOC, CELL_W'(0));
      // FIFO re-free reattaches the tail so the list can drain
      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(0));
      send_item(MODE_FREE, CELL_W'(2));
      send_item(MODE_ALLOC, CELL_W'(1023));
      send_item(MODE_ALLOC, CELL_W'(0));
      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(1));
      send_item(MODE_FREE, CELL_W'(1023));
      send_item(MODE_FREE, CELL_W'(0));
      send_item(MODE_ALLOC, CELL_W'(0));
      send_item(MODE_ALLOC, CELL_W'(0));
      send_item(MODE_ALLOC, CELL_W'(1023));
      send_item(MODE_FREE, CELL_W'(0));
      send_item(MODE_ALLOC, CELL_W'(0));
      drain();
      held_cells.delete();

      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(0));
      write_csr(CSR_MIN_FREE, CSR_DATA_W'(0));
      random_phase(150, 55, 10);

      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(1));
      write_csr(CSR_MIN_FREE, CSR_DATA_W'(100));
      random_phase(150, 60, 5);

      // threshold equal to what all blocks can supply: grow to the limit, then fail
      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(0));
      write_csr(CSR_MIN_FREE, CSR_DATA_W'(1024));
      random_phase(80, 50, 10);

      // return every held cell, then a burst of frees
      drain();
      while (held_cells.size() > 0) begin
         c = held_cells.pop_front();
         send_item(MODE_FREE, c);
      end
      repeat (200) send_item(MODE_FREE, CELL_W'($urandom));

      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(1));
      write_csr(CSR_MIN_FREE, CSR_DATA_W'(0));
      random_phase(100, 50, 10);

      write_csr(CSR_LIFO_ORDER, CSR_DATA_W'(0));
      write_csr(CSR_MIN_FREE, CSR_DATA_W'($urandom_range(1, 1023)));
      random_phase(100, 55, 20);

      drain();
      repeat (20) @(negedge clock);
      $display("summary: %0d requests (%0d allocate, %0d free), %0d results compared",
               alloc_sent + free_sent, alloc_sent, free_sent, checked_count);
      $display("summary: %0d register writes over both push orders and thresholds 0 to 1024",
               csr_writes);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
